// ===== rtl/lpfr_pkg.sv =====
// Shared types and constants for the length-prefixed frame responder.
package lpfr_pkg;

  localparam int unsigned QUEUE_DEPTH = 4;
  localparam int unsigned QUEUE_AW    = $clog2(QUEUE_DEPTH);

  localparam logic [7:0] SYNC_RESET  = 8'hAA;
  localparam logic [7:0] REPLY_RESET = 8'hA4;

  // Fixed bytes of the acknowledgement reply.
  localparam logic [7:0] REPLY_ZERO = 8'h00;
  localparam logic [7:0] REPLY_TWO  = 8'h02;

  localparam logic [7:0] CFG_SYNC_BYTE     = 8'd0;
  localparam logic [7:0] CFG_REPLY_COMMAND = 8'd1;

  localparam int unsigned OUT_TDATA_W = 32;

  typedef enum logic [1:0] {
    PH_HUNT   = 2'd0,
    PH_LEN_HI = 2'd1,
    PH_LEN_LO = 2'd2,
    PH_BODY   = 2'd3
  } phase_e;

  // Position within the run of results caused by one checksum byte.
  typedef enum logic [2:0] {
    IT_REPORT = 3'd0,
    IT_SYNC   = 3'd1,
    IT_ZERO_A = 3'd2,
    IT_TWO    = 3'd3,
    IT_CMD_A  = 3'd4,
    IT_ZERO_B = 3'd5,
    IT_CMD_B  = 3'd6
  } item_e;

  // One finished frame, handed from the parser to the emitter.
  typedef struct packed {
    logic [7:0]  sync;
    logic [7:0]  cmd;
    logic [15:0] len;
    logic        match;
    logic        bad;
    logic        reply;
  } frame_evt_t;

endpackage

// ===== rtl/lpfr_parser.sv =====
// Front part: configuration registers and the byte-level frame parser.
module lpfr_parser (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_valid_i,
  input  logic [7:0]          cfg_index_i,
  input  logic [7:0]          cfg_data_i,
  input  logic                byte_valid_i,
  input  logic [7:0]          byte_i,
  output logic                evt_push_o,
  output lpfr_pkg::frame_evt_t evt_o
);

  logic [7:0]       sync_q, reply_q;
  lpfr_pkg::phase_e phase_q, phase_d;
  logic [15:0]      len_q, len_d;
  logic [16:0]      left_q, left_d;
  logic [7:0]       sum_q, sum_d;
  logic [7:0]       cmd_q, cmd_d;
  logic             first_q, first_d;
  logic             frame_end;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sync_q  <= lpfr_pkg::SYNC_RESET;
      reply_q <= lpfr_pkg::REPLY_RESET;
    end else if (cfg_valid_i) begin
      if (cfg_index_i == lpfr_pkg::CFG_SYNC_BYTE) begin
        sync_q <= cfg_data_i;
      end else if (cfg_index_i == lpfr_pkg::CFG_REPLY_COMMAND) begin
        reply_q <= cfg_data_i;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= lpfr_pkg::PH_HUNT;
      len_q   <= '0;
      left_q  <= '0;
      sum_q   <= '0;
      cmd_q   <= '0;
      first_q <= 1'b0;
    end else begin
      phase_q <= phase_d;
      len_q   <= len_d;
      left_q  <= left_d;
      sum_q   <= sum_d;
      cmd_q   <= cmd_d;
      first_q <= first_d;
    end
  end

  assign frame_end = (left_q <= 17'd1);

  always_comb begin
    phase_d = phase_q;
    len_d   = len_q;
    left_d  = left_q;
    sum_d   = sum_q;
    cmd_d   = cmd_q;
    first_d = first_q;
    evt_push_o = 1'b0;
    if (byte_valid_i) begin
      case (phase_q)
        lpfr_pkg::PH_HUNT: begin
          if (byte_i == sync_q) begin
            phase_d = lpfr_pkg::PH_LEN_HI;
          end
        end
        lpfr_pkg::PH_LEN_HI: begin
          len_d   = {byte_i, 8'h00};
          phase_d = lpfr_pkg::PH_LEN_LO;
        end
        lpfr_pkg::PH_LEN_LO: begin
          len_d   = {len_q[15:8], byte_i};
          left_d  = {1'b0, len_q[15:8], byte_i} + 17'd1;
          sum_d   = '0;
          cmd_d   = '0;
          first_d = 1'b1;
          phase_d = lpfr_pkg::PH_BODY;
        end
        lpfr_pkg::PH_BODY: begin
          if (frame_end) begin
            evt_push_o = 1'b1;
            left_d     = '0;
            first_d    = 1'b0;
            phase_d    = lpfr_pkg::PH_HUNT;
          end else begin
            if (first_q) begin
              cmd_d   = byte_i;
              first_d = 1'b0;
            end
            sum_d  = sum_q + byte_i;
            left_d = left_q - 17'd1;
          end
        end
        default: phase_d = lpfr_pkg::PH_HUNT;
      endcase
    end
  end

  // The event carries everything the emitter needs, so no register value is
  // looked at after the checksum byte.
  always_comb begin
    evt_o.sync  = sync_q;
    evt_o.len   = len_q;
    evt_o.bad   = (len_q == 16'd0);
    evt_o.cmd   = evt_o.bad ? 8'h00 : cmd_q;
    evt_o.match = (sum_q == byte_i);
    evt_o.reply = !evt_o.bad && (cmd_q == reply_q);
  end

endmodule

// ===== rtl/lpfr_queue.sv =====
// Short event queue between the parser and the emitter.
module lpfr_queue (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 push_i,
  input  lpfr_pkg::frame_evt_t data_i,
  output logic                 full_o,
  input  logic                 pop_i,
  output logic                 valid_o,
  output lpfr_pkg::frame_evt_t data_o
);

  lpfr_pkg::frame_evt_t           slot_q [lpfr_pkg::QUEUE_DEPTH];
  logic [lpfr_pkg::QUEUE_AW:0]    wr_ptr_q, rd_ptr_q;

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wr_ptr_q[lpfr_pkg::QUEUE_AW-1:0]] <= data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= wr_ptr_q + 1'b1;
      end
      if (pop_i) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
    end
  end

  assign full_o  = (wr_ptr_q[lpfr_pkg::QUEUE_AW] != rd_ptr_q[lpfr_pkg::QUEUE_AW]) &&
                   (wr_ptr_q[lpfr_pkg::QUEUE_AW-1:0] == rd_ptr_q[lpfr_pkg::QUEUE_AW-1:0]);
  assign valid_o = (wr_ptr_q != rd_ptr_q);
  assign data_o  = slot_q[rd_ptr_q[lpfr_pkg::QUEUE_AW-1:0]];

endmodule

// ===== rtl/lpfr_emitter.sv =====
// Back part: turns each frame event into a report and an optional reply.
module lpfr_emitter (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             evt_valid_i,
  input  lpfr_pkg::frame_evt_t             evt_i,
  output logic                             evt_pop_o,
  output logic                             out_valid_o,
  input  logic                             out_ready_i,
  output logic [lpfr_pkg::OUT_TDATA_W-1:0] out_data_o,
  output logic                             out_kind_o,
  output logic                             out_last_o
);

  logic                 busy_q, busy_d;
  lpfr_pkg::item_e      idx_q, idx_d;
  lpfr_pkg::frame_evt_t evt_q;
  logic                 done;
  logic [7:0]           value;
  logic                 match, bad;
  logic [15:0]          len;

  assign out_valid_o = busy_q;
  assign out_last_o  = (idx_q == lpfr_pkg::IT_CMD_B) ||
                       ((idx_q == lpfr_pkg::IT_REPORT) && !evt_q.reply);
  assign done        = busy_q && out_ready_i && out_last_o;
  assign evt_pop_o   = evt_valid_i && (!busy_q || done);

  always_comb begin
    busy_d = busy_q;
    idx_d  = idx_q;
    if (evt_pop_o) begin
      busy_d = 1'b1;
      idx_d  = lpfr_pkg::IT_REPORT;
    end else if (done) begin
      busy_d = 1'b0;
    end else if (busy_q && out_ready_i) begin
      idx_d = lpfr_pkg::item_e'(idx_q + 3'd1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      idx_q  <= lpfr_pkg::IT_REPORT;
    end else begin
      busy_q <= busy_d;
      idx_q  <= idx_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (evt_pop_o) begin
      evt_q <= evt_i;
    end
  end

  always_comb begin
    match = 1'b0;
    bad   = 1'b0;
    len   = '0;
    case (idx_q)
      lpfr_pkg::IT_REPORT: begin
        value = evt_q.cmd;
        match = evt_q.match;
        bad   = evt_q.bad;
        len   = evt_q.len;
      end
      lpfr_pkg::IT_SYNC:   value = evt_q.sync;
      lpfr_pkg::IT_ZERO_A: value = lpfr_pkg::REPLY_ZERO;
      lpfr_pkg::IT_TWO:    value = lpfr_pkg::REPLY_TWO;
      lpfr_pkg::IT_CMD_A:  value = evt_q.cmd;
      lpfr_pkg::IT_ZERO_B: value = lpfr_pkg::REPLY_ZERO;
      lpfr_pkg::IT_CMD_B:  value = evt_q.cmd;
      default:             value = lpfr_pkg::REPLY_ZERO;
    endcase
  end

  assign out_kind_o = (idx_q != lpfr_pkg::IT_REPORT);
  assign out_data_o = {6'd0, len, bad, match, value};

  a_idx_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q |-> (idx_q <= lpfr_pkg::IT_CMD_B))
    else $error("reply index ran past the last reply byte");

  a_reply_only: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (busy_q && (idx_q != lpfr_pkg::IT_REPORT)) |-> evt_q.reply)
    else $error("reply byte emitted for a frame that takes no reply");

  a_pop_loads: assert property (@(posedge clk_i) disable iff (!rst_ni)
    evt_pop_o |=> (busy_q && (idx_q == lpfr_pkg::IT_REPORT)))
    else $error("new frame event did not start with its report");

  a_no_early_pop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (busy_q && !out_ready_i) |-> !evt_pop_o)
    else $error("event taken while the current result is stalled");

endmodule

// ===== rtl/length_prefixed_frame_responder_top.sv =====
// Top level of the length-prefixed frame responder.
//
// Received serial bytes enter on the s_axis channel, one per transfer. The
// parser hunts for the sync byte, reads a big-endian 16-bit body length,
// the body and a checksum byte, and on the checksum byte queues one frame
// event. The emitter turns each event into a report on m_axis (tuser 0),
// followed by six reply bytes (tuser 1) when the body is not empty and its
// command matches the reply command register; tlast marks the final result
// of a frame. Input runs at one byte per cycle while the four-entry event
// queue has room. Output runs at one result per cycle while m_axis_tready
// is high, a matching frame gives seven results, and the input stalls only
// once the queue is full. A frame's event is written into the queue on its
// checksum byte and, once the emitter is free, into the emitter's register.
// Reset returns the parser to sync hunting, empties the queue and restores
// the sync byte (0xAA) and reply command (0xA4). A stalled receiver holds the
// current result steady; the parser keeps taking bytes until the queue fills.
// Configuration writes through cfg_* are always taken at once.
module length_prefixed_frame_responder_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [7:0]  cfg_index_i,
  input  logic [7:0]  cfg_data_i,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] rx_byte
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // [7:0] data_value, [8] sum_matches, [9] frame_malformed,
  // [25:10] body_length, [31:26] zero
  output logic [31:0] m_axis_tdata,
  output logic        m_axis_tuser,   // [0] item_kind
  output logic        m_axis_tlast    // last_of_run
);

  logic                 q_full, q_valid, q_pop, evt_push, byte_take;
  lpfr_pkg::frame_evt_t evt_in, evt_out;

  assign cfg_ready_o   = 1'b1;
  assign s_axis_tready = !q_full;
  assign byte_take     = s_axis_tvalid && !q_full;

  lpfr_parser u_parser (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .byte_valid_i (byte_take),
    .byte_i       (s_axis_tdata),
    .evt_push_o   (evt_push),
    .evt_o        (evt_in)
  );

  lpfr_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (evt_push),
    .data_i  (evt_in),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .valid_o (q_valid),
    .data_o  (evt_out)
  );

  lpfr_emitter u_emitter (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .evt_valid_i (q_valid),
    .evt_i       (evt_out),
    .evt_pop_o   (q_pop),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_data_o  (m_axis_tdata),
    .out_kind_o  (m_axis_tuser),
    .out_last_o  (m_axis_tlast)
  );

endmodule
